### design/line_pattern_matcher_top_macros.svh
// Assertion macros for the line pattern matcher checker.
// Used by the checker file only; no other dependencies.
`ifndef LINE_PATTERN_MATCHER_TOP_MACROS_SVH
`define LINE_PATTERN_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LPM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line pattern matcher check failed");

// Next-cycle implication, disabled while reset is held.
`define LPM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line pattern matcher check failed");

`endif

### design/lpm_pkg.sv
// Shared types, constants and byte helpers for the line pattern matcher.
// Used by every design module but the checker, and by the bench; depends on nothing.
package lpm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int PIDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int NCELL       = PATTERN_MAX + 1;

    localparam logic [7:0]  NEWLINE     = 8'd10;
    localparam logic [7:0]  CH_DOT      = 8'h2E;
    localparam logic [7:0]  UPPER_A     = 8'd65;
    localparam logic [7:0]  UPPER_Z     = 8'd90;
    localparam logic [7:0]  LOWER_A     = 8'd97;
    localparam logic [7:0]  LOWER_Z     = 8'd122;
    localparam logic [7:0]  UNDERSCORE  = 8'd95;
    localparam logic [7:0]  CASE_GAP    = 8'd32;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] LINEPOS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_FILE = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    localparam logic [2:0] CFG_CASE_INSENSITIVE = 3'd0;
    localparam logic [2:0] CFG_WHOLE_WORD       = 3'd1;
    localparam logic [2:0] CFG_INVERT_MATCH     = 3'd2;
    localparam logic [2:0] CFG_ANCHOR_START     = 3'd3;
    localparam logic [2:0] CFG_ANCHOR_END       = 3'd4;
    localparam logic [2:0] CFG_DOT_WILDCARD     = 3'd5;
    localparam logic [2:0] CFG_PATTERN_LENGTH   = 3'd6;
    localparam logic [2:0] CFG_MAX_COUNT        = 3'd7;

    typedef enum logic [2:0] {
        K_BYTE = 3'b001,
        K_LINE = 3'b010,
        K_FILE = 3'b100
    } t_kind;

    typedef struct packed {
        logic        case_insensitive;
        logic        whole_word;
        logic        invert_match;
        logic        anchor_start;
        logic        anchor_end;
        logic        dot_wildcard;
        logic [6:0]  pattern_length;
        logic [15:0] max_count;
    } t_cfg;

    // One beat handed from the cell row to the line controller.
    typedef struct packed {
        t_kind            kind;
        logic [NCELL-1:0] hit;
        logic [NCELL-1:0] bword;
        logic             gate;
        logic             wchk;
        logic             word;
    } t_a_beat;

    typedef struct packed {
        logic busy;
        logic active;
    } t_pat_status;

    function automatic logic is_word(input logic [7:0] c);
        return (c >= UPPER_A && c <= UPPER_Z) || c == UNDERSCORE ||
               (c >= LOWER_A && c <= LOWER_Z);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_GAP : c;
    endfunction

    function automatic logic bytes_equal(input logic [7:0] p, input logic [7:0] t,
                                         input logic dot, input logic ci);
        logic eq;
        if (dot && p == CH_DOT) begin
            eq = 1'b1;
        end else if (ci) begin
            eq = (fold(p) == fold(t));
        end else begin
            eq = (p == t);
        end
        return eq;
    endfunction

    function automatic logic [LEN_W-1:0] eff_len(input logic [6:0] pl);
        logic [LEN_W-1:0] r;
        if (32'(pl) > PATTERN_MAX) begin
            r = LEN_W'(PATTERN_MAX);
        end else begin
            r = LEN_W'(pl);
        end
        return r;
    endfunction

endpackage

### design/lpm_cell.sv
// One cell of the matcher row: a window byte, an aligned pattern byte and
// the comparison for its position. Depends on lpm_pkg.
module lpm_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [lpm_pkg::LEN_W-1:0] i_index,
    input  logic [lpm_pkg::LEN_W-1:0] i_len,
    input  lpm_pkg::t_cfg            i_cfg,
    input  logic                     i_win_clear,
    input  logic                     i_win_shift,
    input  logic [7:0]               i_win_in,
    output logic [7:0]               o_win,
    input  logic                     i_eval_shift,
    input  logic                     i_pat_shift,
    input  logic [7:0]               i_pat_in,
    output logic [7:0]               o_pat,
    output logic                     o_hit,
    output logic                     o_bword
);
    import lpm_pkg::*;

    logic [7:0] r_win;
    logic [7:0] r_pat;
    logic [7:0] eval_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 8'd0;
        end else if (i_win_clear) begin
            r_win <= 8'd0;
        end else if (i_win_shift) begin
            r_win <= i_win_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pat_shift) begin
            r_pat <= i_pat_in;
        end
    end

    // A text byte is judged on the window as it will be after the shift;
    // a newline is judged on the window as it stands.
    assign eval_byte = i_eval_shift ? i_win_in : r_win;

    assign o_hit   = (i_index >= i_len) ||
                     bytes_equal(r_pat, eval_byte, i_cfg.dot_wildcard, i_cfg.case_insensitive);
    assign o_bword = (i_index == i_len) && is_word(eval_byte);
    assign o_win   = r_win;
    assign o_pat   = r_pat;

endmodule

### design/lpm_pat_loader.sv
// Pattern store and the sweep that copies it, reversed and aligned to the
// pattern length, into the cell row. Depends on lpm_pkg.
module lpm_pat_loader (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [lpm_pkg::PIDX_W-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    input  logic                      i_mark,
    input  logic [lpm_pkg::LEN_W-1:0]  i_len,
    output lpm_pkg::t_pat_status      o_status,
    output logic                      o_shift,
    output logic [7:0]                o_shift_data
);
    import lpm_pkg::*;

    logic [7:0]       r_mem [PATTERN_MAX];
    logic [7:0]       r_rd_data;
    logic [LEN_W-1:0] r_cnt;
    logic             r_dirty;
    logic             r_active;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[r_cnt[PIDX_W-1:0]];
    end

    // Any store write or length change invalidates the copy in the row and
    // restarts the sweep from entry zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty    <= 1'b0;
            r_active   <= 1'b0;
            r_rd_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (i_mark) begin
            r_dirty    <= 1'b1;
            r_active   <= 1'b0;
            r_rd_valid <= 1'b0;
        end else if (r_dirty && !r_active) begin
            r_dirty    <= 1'b0;
            r_active   <= 1'b1;
            r_rd_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (r_active) begin
            if (r_cnt < i_len) begin
                r_cnt      <= r_cnt + LEN_W'(1);
                r_rd_valid <= 1'b1;
            end else begin
                r_rd_valid <= 1'b0;
                if (!r_rd_valid) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    assign o_status.busy   = r_dirty || r_active;
    assign o_status.active = r_active;
    assign o_shift         = r_rd_valid && r_active;
    assign o_shift_data    = r_rd_data;

endmodule

### design/lpm_line_ctrl.sv
// Per-line match state, file counters and the result register.
// Reduces the cell row's hit vectors; depends on lpm_pkg.
module lpm_line_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lpm_pkg::t_cfg            i_cfg,
    input  logic [lpm_pkg::LEN_W-1:0] i_len,
    input  logic                     i_a_valid,
    input  lpm_pkg::t_a_beat         i_a,
    output logic                     o_take,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_line_selected,
    output logic                     o_line_emitted,
    output logic [31:0]              o_line_number,
    output logic [31:0]              o_line_offset,
    output logic [15:0]              o_emitted_total
);
    import lpm_pkg::*;

    logic        r_match_found, n_match_found;
    logic        r_word_end_pending, n_word_end_pending;
    logic [31:0] r_lines_seen, n_lines_seen;
    logic [31:0] r_bytes_seen, n_bytes_seen;
    logic [31:0] r_line_start, n_line_start;
    logic [15:0] r_emitted_count, n_emitted_count;
    logic        r_out_valid;
    logic        r_sel, r_emit;
    logic [31:0] r_number, r_offset;
    logic [15:0] r_total;
    logic        cand, hit_ok, found, selected, emitted;

    assign o_take = i_a_valid && (i_a.kind != K_LINE || !r_out_valid || !i_out_stall);

    assign cand   = (&i_a.hit) && i_a.gate && !(i_a.wchk && (|i_a.bword));
    assign hit_ok = (i_len != '0) && !i_cfg.anchor_end && cand;

    always_comb begin
        n_match_found      = r_match_found;
        n_word_end_pending = r_word_end_pending;
        n_lines_seen       = r_lines_seen;
        n_bytes_seen       = r_bytes_seen;
        n_line_start       = r_line_start;
        n_emitted_count    = r_emitted_count;
        found              = 1'b0;
        selected           = 1'b0;
        emitted            = 1'b0;
        unique case (i_a.kind)
            K_BYTE: begin
                // A whole-word match closes on a non-word byte or the newline.
                n_match_found = r_match_found || (r_word_end_pending && !i_a.word) ||
                                (hit_ok && !i_cfg.whole_word);
                n_word_end_pending = hit_ok && i_cfg.whole_word;
                n_bytes_seen       = r_bytes_seen + 32'd1;
            end
            K_LINE: begin
                if (i_len == '0) begin
                    found = 1'b1;
                end else if (i_cfg.anchor_end) begin
                    found = cand;
                end else begin
                    found = r_match_found || r_word_end_pending;
                end
                selected = found ^ i_cfg.invert_match;
                emitted  = selected && (i_cfg.max_count == COUNT_MAX ||
                                        r_emitted_count < i_cfg.max_count);
                if (emitted && r_emitted_count != COUNT_MAX) begin
                    n_emitted_count = r_emitted_count + 16'd1;
                end
                n_bytes_seen       = r_bytes_seen + 32'd1;
                n_lines_seen       = r_lines_seen + 32'd1;
                n_line_start       = r_bytes_seen + 32'd1;
                n_match_found      = 1'b0;
                n_word_end_pending = 1'b0;
            end
            K_FILE: begin
                n_match_found      = 1'b0;
                n_word_end_pending = 1'b0;
                n_lines_seen       = 32'd0;
                n_bytes_seen       = 32'd0;
                n_line_start       = 32'd0;
                n_emitted_count    = 16'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_found      <= 1'b0;
            r_word_end_pending <= 1'b0;
            r_lines_seen       <= 32'd0;
            r_bytes_seen       <= 32'd0;
            r_line_start       <= 32'd0;
            r_emitted_count    <= 16'd0;
        end else if (o_take) begin
            r_match_found      <= n_match_found;
            r_word_end_pending <= n_word_end_pending;
            r_lines_seen       <= n_lines_seen;
            r_bytes_seen       <= n_bytes_seen;
            r_line_start       <= n_line_start;
            r_emitted_count    <= n_emitted_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_a.kind == K_LINE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_a.kind == K_LINE) begin
            r_sel    <= selected;
            r_emit   <= emitted;
            r_number <= r_lines_seen + 32'd1;
            r_offset <= r_line_start;
            r_total  <= n_emitted_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_selected = r_sel;
    assign o_line_emitted  = r_emit;
    assign o_line_number   = r_number;
    assign o_line_offset   = r_offset;
    assign o_emitted_total = r_total;

endmodule

### design/line_pattern_matcher_top.sv
// A newline beat passes the beat register; once the line controller takes
// it, its result is registered at the output, where a stalled output holds
// it and the row waits behind it. Throughput: one beat per cycle when the
// input is not stalled; the cell row compares every pattern byte with the
// window as each text byte arrives. After a pattern load or pattern_length
// write, the next text beat waits while the store is swept into the row.
// Reset (synchronous, active low) resets config, window and counters.
module line_pattern_matcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic [5:0]  i_pattern_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_line_selected,
    output logic        o_line_emitted,
    output logic [31:0] o_line_number,
    output logic [31:0] o_line_offset,
    output logic [15:0] o_emitted_total
);
    import lpm_pkg::*;

    t_cfg             r_cfg;
    logic [15:0]      r_line_pos;
    logic             r_a_valid;
    t_a_beat          r_a;
    t_a_beat          n_a;
    t_pat_status      pat_st;
    logic [LEN_W-1:0] len;
    logic             in_acc, a_free, take;
    logic             is_text, is_file, is_load, is_nl;
    logic             win_shift, win_clear, pat_shift, mark, wr_en;
    logic [7:0]       pat_data;
    logic [15:0]      pos_ev, len16;
    logic [7:0]       win [NCELL];
    logic [7:0]       pat [NCELL];
    logic [NCELL-1:0] hit, bword;

    assign len     = eff_len(r_cfg.pattern_length);
    assign is_text = (i_opcode == OP_TEXT);
    assign is_file = (i_opcode == OP_FILE);
    assign is_load = (i_opcode == OP_LOAD);
    assign is_nl   = (i_byte_value == NEWLINE);

    assign a_free     = !r_a_valid || take;
    assign o_in_stall = !a_free || (is_text && pat_st.busy) || (is_load && pat_st.active);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign win_shift = in_acc && is_text && !is_nl;
    assign win_clear = in_acc && is_file;
    assign mark      = (in_acc && is_load) || (i_cfg_we && i_cfg_index == CFG_PATTERN_LENGTH);
    assign wr_en     = in_acc && is_load && (32'(i_pattern_index) < PATTERN_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.case_insensitive <= 1'b0;
            r_cfg.whole_word       <= 1'b0;
            r_cfg.invert_match     <= 1'b0;
            r_cfg.anchor_start     <= 1'b0;
            r_cfg.anchor_end       <= 1'b0;
            r_cfg.dot_wildcard     <= 1'b0;
            r_cfg.pattern_length   <= 7'd0;
            r_cfg.max_count        <= COUNT_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CASE_INSENSITIVE: r_cfg.case_insensitive <= i_cfg_data[0];
                CFG_WHOLE_WORD:       r_cfg.whole_word       <= i_cfg_data[0];
                CFG_INVERT_MATCH:     r_cfg.invert_match     <= i_cfg_data[0];
                CFG_ANCHOR_START:     r_cfg.anchor_start     <= i_cfg_data[0];
                CFG_ANCHOR_END:       r_cfg.anchor_end       <= i_cfg_data[0];
                CFG_DOT_WILDCARD:     r_cfg.dot_wildcard     <= i_cfg_data[0];
                CFG_PATTERN_LENGTH:   r_cfg.pattern_length   <= i_cfg_data[6:0];
                CFG_MAX_COUNT:        r_cfg.max_count        <= i_cfg_data;
            endcase
        end
    end

    lpm_pat_loader u_loader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (PIDX_W'(i_pattern_index)),
        .i_wr_data    (i_byte_value),
        .i_mark       (mark),
        .i_len        (len),
        .o_status     (pat_st),
        .o_shift      (pat_shift),
        .o_shift_data (pat_data)
    );

    // Cell k holds window byte k and pattern byte len-1-k; the last cell
    // holds the byte pushed out of the window, needed for the word check.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        lpm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (LEN_W'(k)),
            .i_len        (len),
            .i_cfg        (r_cfg),
            .i_win_clear  (win_clear),
            .i_win_shift  (win_shift),
            .i_win_in     ((k == 0) ? i_byte_value : win[(k == 0) ? 0 : k - 1]),
            .o_win        (win[k]),
            .i_eval_shift (!is_nl),
            .i_pat_shift  (pat_shift),
            .i_pat_in     ((k == 0) ? pat_data : pat[(k == 0) ? 0 : k - 1]),
            .o_pat        (pat[k]),
            .o_hit        (hit[k]),
            .o_bword      (bword[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos <= 16'd0;
        end else if (in_acc && is_text) begin
            if (is_nl) begin
                r_line_pos <= 16'd0;
            end else if (r_line_pos != LINEPOS_MAX) begin
                r_line_pos <= r_line_pos + 16'd1;
            end
        end else if (in_acc && is_file) begin
            r_line_pos <= 16'd0;
        end
    end

    assign len16  = 16'(len);
    assign pos_ev = is_nl ? r_line_pos :
                    ((r_line_pos == LINEPOS_MAX) ? LINEPOS_MAX : r_line_pos + 16'd1);

    always_comb begin
        n_a.kind  = is_file ? K_FILE : (is_nl ? K_LINE : K_BYTE);
        n_a.hit   = hit;
        n_a.bword = bword;
        n_a.gate  = (pos_ev >= len16) && (!r_cfg.anchor_start || pos_ev == len16);
        n_a.wchk  = r_cfg.whole_word && (pos_ev > len16);
        n_a.word  = is_word(i_byte_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= in_acc && (is_text || is_file);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && in_acc) begin
            r_a <= n_a;
        end
    end

    lpm_line_ctrl u_line (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_len           (len),
        .i_a_valid       (r_a_valid),
        .i_a             (r_a),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_selected (o_line_selected),
        .o_line_emitted  (o_line_emitted),
        .o_line_number   (o_line_number),
        .o_line_offset   (o_line_offset),
        .o_emitted_total (o_emitted_total)
    );

endmodule

### design/lpm_checker.sv
// Port-level checks for the line pattern matcher, bound to the top level.
// Depends on line_pattern_matcher_top_macros.svh.
`include "line_pattern_matcher_top_macros.svh"

module lpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_line_selected,
    input logic        o_line_emitted,
    input logic [31:0] o_line_number,
    input logic [31:0] o_line_offset,
    input logic [15:0] o_emitted_total
);

    `LPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `LPM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_line_number) && $stable(o_line_offset) && $stable(o_emitted_total))
    // An emitted line must also be a selected line.
    `LPM_ASSERT_IMPL(a_emit_needs_select, i_clk, i_rst_n, o_out_valid && o_line_emitted, o_line_selected)
    // The running total already counts an emitted line.
    `LPM_ASSERT_IMPL(a_emit_counted, i_clk, i_rst_n, o_out_valid && o_line_emitted, o_emitted_total != 16'd0)

endmodule

bind line_pattern_matcher_top lpm_checker u_lpm_checker (.*);

### bench/line_match_checker.sv
// Checker for the line pattern matcher: follows the config port and both
// channels, predicts one line report per newline beat and compares in order.
// Depends on lpm_pkg for the opcode enum, register indexes and byte constants.
module line_match_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic [5:0]  i_pattern_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_line_selected,
    input  logic        i_line_emitted,
    input  logic [31:0] i_line_number,
    input  logic [31:0] i_line_offset,
    input  logic [15:0] i_emitted_total,
    output int          o_fail_count,
    output int          o_lines_pending
);
    import lpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        selected;
        logic        emitted;
        logic [31:0] number;
        logic [31:0] offset;
        logic [15:0] total;
    } t_line_report;

    t_line_report expected_lines[$];

    t_cfg        cfg;
    logic [7:0]  pat_mem [PATTERN_MAX];
    logic [7:0]  window [PATTERN_MAX];
    logic [7:0]  shifted_out;
    logic [15:0] line_pos;
    logic [31:0] line_count;
    logic [31:0] byte_count;
    logic [31:0] line_base;
    logic [15:0] emit_count;
    logic        match_seen;
    logic        word_tail_wait;

    function automatic logic word_byte(input logic [7:0] c);
        logic upper;
        logic lower;
        upper = (c >= UPPER_A) && (c <= UPPER_Z);
        lower = (c >= LOWER_A) && (c <= LOWER_Z);
        return upper || lower || (c == UNDERSCORE);
    endfunction

    // Uppercase letters have bit 5 clear, so setting it lowers them.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= UPPER_A) && (c <= UPPER_Z)) ? (c | 8'h20) : c;
    endfunction

    function automatic logic pattern_hit(input logic [7:0] p, input logic [7:0] t);
        if (cfg.dot_wildcard && p == CH_DOT) begin
            return 1'b1;
        end
        if (cfg.case_insensitive) begin
            return to_lower(p) == to_lower(t);
        end
        return p == t;
    endfunction

    // True when the pattern ends at the newest byte and anchor/word checks pass.
    function automatic logic match_ends_here(input int unsigned len);
        logic [7:0] lead_byte;
        if (line_pos < len) begin
            return 1'b0;
        end
        for (int unsigned p = 0; p < len; p++) begin
            if (!pattern_hit(pat_mem[p], window[len - 1 - p])) begin
                return 1'b0;
            end
        end
        if (cfg.anchor_start && line_pos != len) begin
            return 1'b0;
        end
        if (cfg.whole_word && line_pos > len) begin
            lead_byte = (len < PATTERN_MAX) ? window[len] : shifted_out;
            if (word_byte(lead_byte)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void clear_file_state();
        foreach (window[k]) begin
            window[k] = 8'h00;
        end
        shifted_out    = 8'h00;
        line_pos       = '0;
        line_count     = '0;
        byte_count     = '0;
        line_base      = '0;
        emit_count     = '0;
        match_seen     = 1'b0;
        word_tail_wait = 1'b0;
    endfunction

    function automatic void predict_beat(input t_opcode op, input logic [7:0] b,
                                         input logic [5:0] idx);
        int unsigned  len;
        logic         found;
        t_line_report rep;
        len = (cfg.pattern_length > PATTERN_MAX) ? PATTERN_MAX : cfg.pattern_length;
        case (op)
            OP_LOAD: pat_mem[idx] = b;
            OP_FILE: clear_file_state();
            OP_TEXT: begin
                if (b != NEWLINE) begin
                    // Whole-word matches end at a non-word byte or the newline.
                    if (word_tail_wait && !word_byte(b)) begin
                        match_seen = 1'b1;
                    end
                    word_tail_wait = 1'b0;
                    shifted_out = window[PATTERN_MAX - 1];
                    for (int k = PATTERN_MAX - 1; k > 0; k--) begin
                        window[k] = window[k - 1];
                    end
                    window[0] = b;
                    if (line_pos != LINEPOS_MAX) begin
                        line_pos++;
                    end
                    if (len > 0 && !cfg.anchor_end && match_ends_here(len)) begin
                        if (cfg.whole_word) begin
                            word_tail_wait = 1'b1;
                        end else begin
                            match_seen = 1'b1;
                        end
                    end
                    byte_count++;
                end else begin
                    if (len == 0) begin
                        found = 1'b1;
                    end else if (cfg.anchor_end) begin
                        found = match_ends_here(len);
                    end else begin
                        found = match_seen || word_tail_wait;
                    end
                    rep.selected = found ^ cfg.invert_match;
                    rep.emitted  = rep.selected &&
                                   (cfg.max_count == COUNT_MAX || emit_count < cfg.max_count);
                    if (rep.emitted && emit_count != COUNT_MAX) begin
                        emit_count++;
                    end
                    rep.number = line_count + 32'd1;
                    rep.offset = line_base;
                    rep.total  = emit_count;
                    expected_lines.push_back(rep);
                    byte_count++;
                    line_count++;
                    line_base      = byte_count;
                    line_pos       = '0;
                    match_seen     = 1'b0;
                    word_tail_wait = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string what, input t_line_report want,
                                         input t_line_report got);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected sel=%0b emit=%0b line=%0d offset=%0d total=%0d",
                     $realtime, what, want.selected, want.emitted, want.number,
                     want.offset, want.total);
            $display("    got sel=%0b emit=%0b line=%0d offset=%0d total=%0d",
                     got.selected, got.emitted, got.number, got.offset, got.total);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_line_report got;
        t_line_report want;
        if (!i_rst_n) begin
            cfg = '0;
            cfg.max_count = COUNT_MAX;
            clear_file_state();
            expected_lines.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CASE_INSENSITIVE: cfg.case_insensitive = i_cfg_data[0];
                    CFG_WHOLE_WORD:       cfg.whole_word       = i_cfg_data[0];
                    CFG_INVERT_MATCH:     cfg.invert_match     = i_cfg_data[0];
                    CFG_ANCHOR_START:     cfg.anchor_start     = i_cfg_data[0];
                    CFG_ANCHOR_END:       cfg.anchor_end       = i_cfg_data[0];
                    CFG_DOT_WILDCARD:     cfg.dot_wildcard     = i_cfg_data[0];
                    CFG_PATTERN_LENGTH:   cfg.pattern_length   = i_cfg_data[6:0];
                    CFG_MAX_COUNT:        cfg.max_count        = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(t_opcode'(i_opcode), i_byte_value, i_pattern_index);
            end
            if (i_out_valid && !i_out_stall) begin
                got.selected = i_line_selected;
                got.emitted  = i_line_emitted;
                got.number   = i_line_number;
                got.offset   = i_line_offset;
                got.total    = i_emitted_total;
                if (expected_lines.size() == 0) begin
                    note_failure("report with no line pending", '0, got);
                end else begin
                    want = expected_lines.pop_front();
                    if (got.selected !== want.selected || got.emitted !== want.emitted ||
                        got.number !== want.number || got.offset !== want.offset ||
                        got.total !== want.total) begin
                        note_failure("line report differs", want, got);
                    end
                end
            end
        end
        o_lines_pending = expected_lines.size();
    end

endmodule

### bench/tb.sv
// Top of the line pattern matcher bench: clock, reset, config writes and
// byte stimulus with random gaps and output stalls; line_match_checker judges.
// Depends on lpm_pkg, line_pattern_matcher_top and line_match_checker.
module tb;
    import lpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = PATTERN_MAX + 16;
    // Far above the slowest legal run: every beat held by gaps, every report
    // held by a long stall, and a full store sweep after each pattern load.
    localparam int CYCLE_LIMIT   = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [7:0]  i_byte_value;
    logic [5:0]  i_pattern_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_line_selected;
    logic        o_line_emitted;
    logic [31:0] o_line_number;
    logic [31:0] o_line_offset;
    logic [15:0] o_emitted_total;

    int mismatches;
    int lines_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;

    // Shadow of the current settings, used to shape the text.
    logic       opt_ci;
    logic       opt_ww;
    logic       opt_dot;
    logic       opt_a_start;
    logic       opt_a_end;
    int         pat_len;
    logic [7:0] pat_bytes [PATTERN_MAX];

    line_pattern_matcher_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_byte_value    (i_byte_value),
        .i_pattern_index (i_pattern_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_selected (o_line_selected),
        .o_line_emitted  (o_line_emitted),
        .o_line_number   (o_line_number),
        .o_line_offset   (o_line_offset),
        .o_emitted_total (o_emitted_total)
    );

    line_match_checker CHECK (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_byte_value    (i_byte_value),
        .i_pattern_index (i_pattern_index),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_line_selected (o_line_selected),
        .i_line_emitted  (o_line_emitted),
        .i_line_number   (o_line_number),
        .i_line_offset   (o_line_offset),
        .i_emitted_total (o_emitted_total),
        .o_fail_count    (mismatches),
        .o_lines_pending (lines_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] filler_byte();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 22) begin
            c = $urandom_range(1) ? "a" : "b";
        end else if (r < 36) begin
            c = $urandom_range(1) ? "A" : "B";
        end else if (r < 42) begin
            c = "c";
        end else if (r < 50) begin
            c = "_";
        end else if (r < 64) begin
            c = " ";
        end else if (r < 71) begin
            c = CH_DOT;
        end else if (r < 77) begin
            c = "-";
        end else begin
            do begin
                c = 8'($urandom);
            end while (c == NEWLINE);
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte();
        if ($urandom_range(99) < 6) begin
            return $urandom_range(1) ? "^" : "$";
        end
        return filler_byte();
    endfunction

    function automatic logic [15:0] flag_word(input logic f);
        logic [15:0] w;
        w = 16'($urandom);
        w[0] = f;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input t_opcode op, input logic [7:0] b, input logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_byte_value    <= b;
        i_pattern_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (op != OP_NONE) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_beat(OP_TEXT, s[k], 6'($urandom));
        end
    endtask

    // Holds the sender until every report is out and the block has gone quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (lines_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic ci, input logic ww, input logic inv,
                                  input logic a_start, input logic a_end, input logic dot,
                                  input logic [6:0] len, input logic [15:0] limit);
        settle();
        opt_ci      = ci;
        opt_ww      = ww;
        opt_dot     = dot;
        opt_a_start = a_start;
        opt_a_end   = a_end;
        pat_len     = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
        write_reg(CFG_CASE_INSENSITIVE, flag_word(ci));
        write_reg(CFG_WHOLE_WORD, flag_word(ww));
        write_reg(CFG_INVERT_MATCH, flag_word(inv));
        write_reg(CFG_ANCHOR_START, flag_word(a_start));
        write_reg(CFG_ANCHOR_END, flag_word(a_end));
        write_reg(CFG_DOT_WILDCARD, flag_word(dot));
        write_reg(CFG_PATTERN_LENGTH, {9'($urandom), len});
        write_reg(CFG_MAX_COUNT, limit);
        i_cfg_we <= 1'b0;
    endtask

    // New settings, a fresh pattern over every entry in use, then a new file.
    task automatic program_phase(input int phase_no);
        logic [5:0]  flags;
        logic [6:0]  len;
        logic [15:0] limit;
        int          r;
        flags = 6'($urandom);
        r = $urandom_range(99);
        if (r < 6) begin
            len = 7'd0;
        end else if (r < 80) begin
            len = 7'($urandom_range(6, 1));
        end else if (r < 92) begin
            len = 7'($urandom_range(20, 7));
        end else if (r < 96) begin
            len = 7'd64;
        end else begin
            len = 7'($urandom_range(127, 65));
        end
        r = $urandom_range(99);
        if (r < 40) begin
            limit = COUNT_MAX;
        end else if (r < 55) begin
            limit = 16'd0;
        end else if (r < 70) begin
            limit = 16'($urandom_range(3, 1));
        end else if (r < 85) begin
            limit = 16'($urandom_range(40, 4));
        end else begin
            limit = 16'($urandom);
        end
        if (phase_no == 0) begin
            flags = '1;
            len   = 7'd64;
            limit = 16'd0;
        end else if (phase_no == 1) begin
            flags = '0;
            len   = 7'd127;
            limit = COUNT_MAX;
        end
        apply_settings(flags[0], flags[1], flags[2], flags[3], flags[4], flags[5],
                       len, limit);
        for (int k = 0; k < pat_len; k++) begin
            pat_bytes[k] = pattern_byte();
            send_beat(OP_LOAD, pat_bytes[k], 6'(k));
        end
        send_beat(OP_FILE, 8'($urandom), 6'($urandom));
    endtask

    // Filler around an optional copy of the pattern, bent the way the
    // options allow so that most copies still match.
    task automatic send_random_line();
        logic [7:0] text[$];
        logic [7:0] c;
        int         lead;
        int         trail;
        lead  = (opt_a_start && $urandom_range(1)) ? 0 : $urandom_range(6);
        trail = (opt_a_end && $urandom_range(1)) ? 0 : $urandom_range(6);
        if (opt_ww && $urandom_range(1)) begin
            lead  = (lead == 0) ? 0 : 1;
            trail = (trail == 0) ? 0 : 1;
        end
        for (int k = 0; k < lead; k++) begin
            text.push_back(filler_byte());
        end
        if (pat_len > 0 && $urandom_range(99) < 65) begin
            for (int k = 0; k < pat_len; k++) begin
                c = pat_bytes[k];
                if (opt_dot && c == CH_DOT) begin
                    c = filler_byte();
                end else if (opt_ci && $urandom_range(1) &&
                             ((c >= UPPER_A && c <= UPPER_Z) ||
                              (c >= LOWER_A && c <= LOWER_Z))) begin
                    c = c ^ CASE_GAP;
                end
                text.push_back(c);
            end
            if ($urandom_range(99) < 15) begin
                text[$urandom_range(text.size() - 1)] = filler_byte();
            end
        end
        for (int k = 0; k < trail; k++) begin
            text.push_back(filler_byte());
        end
        foreach (text[j]) begin
            send_beat(OP_TEXT, text[j], 6'($urandom));
        end
        send_beat(OP_TEXT, NEWLINE, 6'($urandom));
    endtask

    initial begin : stimulus
        int         phase_no;
        int         n_lines;
        int         r;
        int         slot;
        logic [7:0] c;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_CASE_INSENSITIVE;
        i_cfg_data      = 16'h0000;
        i_in_valid      = 1'b0;
        i_opcode        = OP_LOAD;
        i_byte_value    = 8'h00;
        i_pattern_index = 6'd0;
        send_idle_pct   = 10;
        recv_stall_pct  = 87;
        items_sent      = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: folding, dot wildcard, literal dollar, whole-word edges,
        // max_count, ignored opcode, new file, unterminated line.
        apply_settings(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'd3, 16'd1);
        send_beat(OP_LOAD, "x", 6'd0);
        send_beat(OP_LOAD, CH_DOT, 6'd1);
        send_beat(OP_LOAD, "$", 6'd2);
        send_beat(OP_LOAD, 8'hFF, 6'd63);
        send_beat(OP_LOAD, 8'h00, 6'd5);
        send_beat(OP_FILE, 8'h00, 6'd0);
        send_text("X$$\n");
        send_text("ax.$ \n");
        send_text("x?$\n");
        send_beat(OP_NONE, 8'hA5, 6'h2A);
        send_beat(OP_FILE, 8'h5A, 6'h15);
        send_text("xy");
        send_beat(OP_FILE, 8'hFF, 6'h3F);
        // An empty pattern matches every line, so inversion drops it.
        apply_settings(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, COUNT_MAX);
        send_text("^$\n");

        items_sent = 0;
        phase_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct  = 10;
                recv_stall_pct = 87;
            end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 87;
                recv_stall_pct = 10;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            program_phase(phase_no);
            phase_no++;
            n_lines = (pat_len > 20) ? $urandom_range(6, 3) : $urandom_range(24, 6);
            for (int ln = 0; ln < n_lines; ln++) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    send_beat(OP_NONE, 8'($urandom), 6'($urandom));
                end else if (r < 6) begin
                    slot = $urandom_range(PATTERN_MAX - 1);
                    c    = 8'($urandom);
                    pat_bytes[slot] = c;
                    send_beat(OP_LOAD, c, 6'(slot));
                end else if (r < 8) begin
                    // A new file cuts the current line short.
                    send_beat(OP_TEXT, filler_byte(), 6'($urandom));
                    send_beat(OP_FILE, 8'($urandom), 6'($urandom));
                end
                send_random_line();
            end
        end

        settle();
        if (mismatches == 0 && lines_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/lpm_pkg.sv
design/lpm_cell.sv
design/lpm_pat_loader.sv
design/lpm_line_ctrl.sv
design/line_pattern_matcher_top.sv
design/lpm_checker.sv
bench/line_match_checker.sv
bench/tb.sv
